/* rtl/lfr_pkg.sv */
// ----------------------------------------------------------------------------
// lfr_pkg
// Types and constants shared by the LCD frame buffer refresh block.
// ----------------------------------------------------------------------------
package lfr_pkg;

  localparam int unsigned COLUMNS = 128;
  localparam int unsigned PAGES   = 4;

  localparam int unsigned COL_W   = $clog2(COLUMNS);
  localparam int unsigned PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned ADDR_W  = PAGE_W + COL_W;
  localparam int unsigned DEPTH   = 2 ** ADDR_W;
  // offset inside one page span: three command bytes then the column bytes
  localparam int unsigned SPAN    = COLUMNS + 3;
  localparam int unsigned OFF_W   = $clog2(SPAN);

  // panel command bytes
  localparam logic [7:0] CMD_DISPLAY_OFF = 8'hAE;
  localparam logic [7:0] CMD_START_LINE  = 8'h40;
  localparam logic [7:0] CMD_PAGE_BASE   = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH    = 8'h10;
  localparam logic [7:0] CMD_COL_LOW     = 8'h00;
  localparam logic [7:0] CMD_DISPLAY_ON  = 8'hAF;

  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_REFRESH = 2'd2,
    OP_BLANK   = 2'd3
  } lfr_op_e;

  // what the second step of an item does
  typedef enum logic [1:0] {
    KIND_SET,
    KIND_CLEAR,
    KIND_MEM_BYTE,
    KIND_CONST_BYTE
  } lfr_kind_e;

  // position inside the panel update sequence
  typedef enum logic [1:0] {
    SEQ_OFF,
    SEQ_START,
    SEQ_PAGE,
    SEQ_ON
  } lfr_seq_e;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } lfr_wr_t;

endpackage

/* rtl/lfr_store.sv */
// ----------------------------------------------------------------------------
// lfr_store
// Frame store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lfr_store (
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [lfr_pkg::ADDR_W-1:0] rd_addr_i,
  output logic [7:0]             rd_data_o,
  input  lfr_pkg::lfr_wr_t       wr_i
);
  import lfr_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/lcd_framebuffer_refresh.sv */
// ----------------------------------------------------------------------------
// lcd_framebuffer_refresh
// Paged monochrome frame buffer with a panel update byte sequencer.
//
//   port group   dir  tdata / tuser / tlast
//   s_axis       in   tdata[15:0] = op[1:0], pixel_row[6:2], pixel_col[13:7]
//   m_axis       out  tdata[7:0] = out_byte, tuser = is_data, tlast = frame_last
//
// Every word goes through two steps: a read of the frame store, then a
// modify and write back or a load of the output register. The next word is
// taken once the second step is done; a pending output word does not block
// intake as long as the output is taken in the same cycle.
// After reset a clearing pass writes zeros to all DEPTH (512) entries, one
// a cycle; no word is taken during those cycles.
// ----------------------------------------------------------------------------
module lcd_framebuffer_refresh (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // op[1:0], pixel_row[6:2], pixel_col[13:7]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  output logic        m_axis_tuser,   // is_data[0]
  output logic        m_axis_tlast    // frame_last
);
  import lfr_pkg::*;

  lfr_op_e          in_op;
  logic [4:0]       in_row;
  logic [6:0]       in_col;
  logic             accept;

  // clearing pass
  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_addr_q;

  // sequencer
  lfr_seq_e          seq_q, seq_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic [7:0]        seq_byte;
  logic              seq_data;
  logic              seq_last;
  logic [ADDR_W-1:0] seq_addr;

  // item in its second step
  logic              st_valid_q;
  lfr_kind_e         st_kind_q;
  logic [7:0]        st_byte_q;
  logic [7:0]        st_mask_q;
  logic [ADDR_W-1:0] st_addr_q;
  logic              st_data_q;
  logic              st_last_q;

  // output register
  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              out_data_q;
  logic              out_last_q;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  lfr_wr_t           wr;

  logic              pix_ok;
  logic [ADDR_W-1:0] pix_addr;
  logic              is_tick;
  logic              emit;

  assign in_op  = lfr_op_e'(s_axis_tdata[1:0]);
  assign in_row = s_axis_tdata[6:2];
  assign in_col = s_axis_tdata[13:7];

  assign s_axis_tready = !clr_busy_q && !st_valid_q && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_tick       = (in_op == OP_REFRESH) || (in_op == OP_BLANK);

  assign pix_ok   = (32'(in_row[4:3]) < PAGES) && (32'(in_col) < COLUMNS);
  assign pix_addr = {PAGE_W'(in_row[4:3]), COL_W'(in_col)};

  // ---- sequencer: byte for the current position, next position ----
  always_comb begin
    seq_d    = seq_q;
    page_d   = page_q;
    off_d    = off_q;
    seq_byte = CMD_COL_LOW;
    seq_data = 1'b0;
    seq_last = 1'b0;
    seq_addr = {page_q, COL_W'(off_q - OFF_W'(3))};
    case (seq_q)
      SEQ_OFF: begin
        seq_byte = CMD_DISPLAY_OFF;
        seq_d    = SEQ_START;
      end
      SEQ_START: begin
        seq_byte = CMD_START_LINE;
        seq_d    = SEQ_PAGE;
        page_d   = '0;
        off_d    = '0;
      end
      SEQ_PAGE: begin
        case (off_q)
          OFF_W'(0): seq_byte = CMD_PAGE_BASE + 8'(page_q);
          OFF_W'(1): seq_byte = CMD_COL_HIGH;
          OFF_W'(2): seq_byte = CMD_COL_LOW;
          default:   seq_data = 1'b1;
        endcase
        if (off_q == OFF_W'(SPAN - 1)) begin
          off_d = '0;
          if (page_q == PAGE_W'(PAGES - 1)) begin
            seq_d = SEQ_ON;
          end else begin
            page_d = page_q + PAGE_W'(1);
          end
        end else begin
          off_d = off_q + OFF_W'(1);
        end
      end
      SEQ_ON: begin
        seq_byte = CMD_DISPLAY_ON;
        seq_last = 1'b1;
        seq_d    = SEQ_OFF;
      end
      default: seq_d = SEQ_OFF;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= SEQ_OFF;
      page_q <= '0;
      off_q  <= '0;
    end else if (accept && is_tick) begin
      seq_q  <= seq_d;
      page_q <= page_d;
      off_q  <= off_d;
    end
  end

  // ---- clearing pass ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---- first step: read the store, capture the item ----
  assign rd_en   = accept;
  assign rd_addr = is_tick ? seq_addr : pix_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else begin
      // drop pixel words that fall outside the panel
      st_valid_q <= accept && (is_tick || pix_ok);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_addr_q <= pix_addr;
      st_mask_q <= 8'(1) << in_row[2:0];
      st_byte_q <= seq_byte;
      st_data_q <= seq_data;
      st_last_q <= seq_last;
      case (in_op)
        OP_SET:     st_kind_q <= KIND_SET;
        OP_CLEAR:   st_kind_q <= KIND_CLEAR;
        OP_REFRESH: st_kind_q <= seq_data ? KIND_MEM_BYTE : KIND_CONST_BYTE;
        default:    st_kind_q <= KIND_CONST_BYTE;
      endcase
    end
  end

  // ---- second step: write back or emit ----
  assign emit = st_valid_q && ((st_kind_q == KIND_MEM_BYTE) ||
                               (st_kind_q == KIND_CONST_BYTE));

  always_comb begin
    wr.en   = 1'b0;
    wr.addr = st_addr_q;
    wr.data = rd_data;
    if (clr_busy_q) begin
      wr.en   = 1'b1;
      wr.addr = clr_addr_q;
      wr.data = '0;
    end else if (st_valid_q) begin
      case (st_kind_q)
        KIND_SET: begin
          wr.en   = 1'b1;
          wr.data = rd_data | st_mask_q;
        end
        KIND_CLEAR: begin
          wr.en   = 1'b1;
          wr.data = rd_data & ~st_mask_q;
        end
        default: wr.en = 1'b0;
      endcase
    end
  end

  lfr_store u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_i      (wr)
  );

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= (st_kind_q == KIND_MEM_BYTE) ? rd_data : st_byte_q;
      out_data_q <= st_data_q;
      out_last_q <= st_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // ---- checks ----
  a_no_intake_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clr_busy_q |-> !s_axis_tready
  ) else $error("word taken during clearing pass");

  a_no_overlap: assert property (
    @(posedge clk_i) disable iff (!rst_ni) st_valid_q |-> !s_axis_tready
  ) else $error("word taken while previous one still in progress");

  a_output_free_on_emit: assert property (
    @(posedge clk_i) disable iff (!rst_ni) emit |-> !out_valid_q
  ) else $error("output register overwritten");

  a_tick_emits_next: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (accept && is_tick) |=> emit
  ) else $error("tick word produced no output");

  a_last_is_display_on: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == CMD_DISPLAY_ON && !m_axis_tuser)
  ) else $error("last word is not the display-on command");

endmodule
